// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh : shared assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define TTB_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("never-condition seen");

// ante implies cons in the same cycle
`define TTB_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication broken");

`endif

// ----- rtl/core/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg : shared constants and types
// Formats, widths and the control struct for the tangent/bitangent block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttb_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int UV_BITS_DEF    = 16;
  localparam int POS_W          = 48;
  localparam int UV_W           = 32;
  localparam int OUT_W          = 32;
  // out frac + uv frac - pos frac
  localparam int QSHIFT         = 20;
  localparam int QBITS          = 32;

  typedef struct packed {
    logic valid;
    logic degenerate;
  } ctl_t;

endpackage

// ----- rtl/core/triangle_tangent_bitangent.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent : per-triangle tangent and bitangent
// Path: 3 decode stages, queue, 36 divider stages.
// Throughput: one triangle per cycle; each divider lane retires one request a
//   cycle, so busy stays low and the receiver cannot stall.
// Reset: synchronous rst empties the pipeline and queue; no done after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_tangent_bitangent #(
  parameter int COORD_BITS = ttb_pkg::COORD_BITS_DEF,
  parameter int UV_BITS    = ttb_pkg::UV_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ttb_pkg::POS_W-1:0]         pos_a,
  input  logic [ttb_pkg::POS_W-1:0]         pos_b,
  input  logic [ttb_pkg::POS_W-1:0]         pos_c,
  input  logic [ttb_pkg::UV_W-1:0]          uv_a,
  input  logic [ttb_pkg::UV_W-1:0]          uv_b,
  input  logic [ttb_pkg::UV_W-1:0]          uv_c,
  output logic                              done,
  output logic signed [ttb_pkg::OUT_W-1:0]  tangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0]  tangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0]  tangent_z,
  output logic signed [ttb_pkg::OUT_W-1:0]  bitangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0]  bitangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0]  bitangent_z,
  output logic                              degenerate
);

  // numerator: edge (C+1) times UV delta (U+1), difference of two -> +1
  localparam int NW = COORD_BITS + UV_BITS + 3;
  // determinant: UV delta squared, difference of two
  localparam int DW = 2 * UV_BITS + 3;
  localparam int QW = 6 * NW + DW + 1;

  logic          accept;
  logic          front_push;
  logic [QW-1:0] front_data;
  logic [QW-1:0] q_data;
  logic          q_empty;
  logic          q_full;
  logic          back_take;
  logic          vec_zero;
  logic signed [ttb_pkg::OUT_W-1:0] res [6];

  // A request is taken whenever the queue has room. The back drains one entry
  // every cycle it holds one, so the queue never fills in practice.
  assign busy   = q_full;
  assign accept = start && !busy;

  ttb_front #(
    .COORD_BITS(COORD_BITS),
    .UV_BITS   (UV_BITS),
    .NW        (NW),
    .DW        (DW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pos_a  (pos_a),
    .pos_b  (pos_b),
    .pos_c  (pos_c),
    .uv_a   (uv_a),
    .uv_b   (uv_b),
    .uv_c   (uv_c),
    .push   (front_push),
    .payload(front_data)
  );

  ttb_queue #(
    .W(QW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_push),
    .din  (front_data),
    .pop  (back_take),
    .dout (q_data),
    .empty(q_empty),
    .full (q_full)
  );

  // back pops whenever the queue is not empty: the divider never holds
  assign back_take = !q_empty;

  ttb_back #(
    .NW(NW),
    .DW(DW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .take      (back_take),
    .payload   (q_data),
    .strobe    (done),
    .degenerate(degenerate),
    .res       (res)
  );

  // lane order: tangent x y z, then bitangent x y z
  assign tangent_x   = res[0];
  assign tangent_y   = res[1];
  assign tangent_z   = res[2];
  assign bitangent_x = res[3];
  assign bitangent_y = res[4];
  assign bitangent_z = res[5];

  assign vec_zero = (tangent_x == 0) && (tangent_y == 0) && (tangent_z == 0) &&
                    (bitangent_x == 0) && (bitangent_y == 0) && (bitangent_z == 0);

  // a request reaching a full queue would be lost
  `TTB_NEVER(a_no_queue_overflow, clk, rst, front_push && q_full)
  // a zero determinant must give zero vectors
  `TTB_IMPLY(a_degen_zero, clk, rst, done && degenerate, vec_zero)
  // queue must stay drained by the back
  `TTB_NEVER(a_never_busy, clk, rst, busy)

endmodule

// ----- rtl/core/ttb_front.sv -----
// ----------------------------------------------------------------------------
// ttb_front : triangle decode
// Unpacks fields, forms edges and UV deltas, products, numerators and
// determinant, flags a zero determinant. Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_front #(
  parameter int COORD_BITS = ttb_pkg::COORD_BITS_DEF,
  parameter int UV_BITS    = ttb_pkg::UV_BITS_DEF,
  parameter int NW         = COORD_BITS + UV_BITS + 3,
  parameter int DW         = 2 * UV_BITS + 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [ttb_pkg::POS_W-1:0]   pos_a,
  input  logic [ttb_pkg::POS_W-1:0]   pos_b,
  input  logic [ttb_pkg::POS_W-1:0]   pos_c,
  input  logic [ttb_pkg::UV_W-1:0]    uv_a,
  input  logic [ttb_pkg::UV_W-1:0]    uv_b,
  input  logic [ttb_pkg::UV_W-1:0]    uv_c,
  output logic                        push,
  output logic [6*NW+DW:0]            payload
);

  localparam int C   = COORD_BITS;
  localparam int U   = UV_BITS;
  localparam int PW  = 3 * C;
  localparam int UW  = 2 * U;
  localparam int PRW = C + U + 2;
  localparam int DPW = 2 * U + 2;

  logic [PW+ttb_pkg::POS_W-1:0] pa_x, pb_x, pc_x;
  logic [UW+ttb_pkg::UV_W-1:0]  ua_x, ub_x, uc_x;

  assign pa_x = {{PW{1'b0}}, pos_a};
  assign pb_x = {{PW{1'b0}}, pos_b};
  assign pc_x = {{PW{1'b0}}, pos_c};
  assign ua_x = {{UW{1'b0}}, uv_a};
  assign ub_x = {{UW{1'b0}}, uv_b};
  assign uc_x = {{UW{1'b0}}, uv_c};

  // stage 1: deltas
  logic signed [C:0] dp1_next [3];
  logic signed [C:0] dp2_next [3];
  logic signed [U:0] du1_next, dv1_next, du2_next, dv2_next;
  logic signed [C:0] dp1 [3];
  logic signed [C:0] dp2 [3];
  logic signed [U:0] du1, dv1, du2, dv2;
  logic              v1, v2, v3;

  always_comb begin
    logic [C-1:0] fa, fb, fc;
    logic [U-1:0] a0, a1, b0, b1, c0, c1;
    for (int k = 0; k < 3; k++) begin
      fa = pa_x[k*C +: C];
      fb = pb_x[k*C +: C];
      fc = pc_x[k*C +: C];
      dp1_next[k] = $signed({fb[C-1], fb}) - $signed({fa[C-1], fa});
      dp2_next[k] = $signed({fc[C-1], fc}) - $signed({fa[C-1], fa});
    end
    a0 = ua_x[0 +: U];
    a1 = ua_x[U +: U];
    b0 = ub_x[0 +: U];
    b1 = ub_x[U +: U];
    c0 = uc_x[0 +: U];
    c1 = uc_x[U +: U];
    du1_next = $signed({b0[U-1], b0}) - $signed({a0[U-1], a0});
    dv1_next = $signed({b1[U-1], b1}) - $signed({a1[U-1], a1});
    du2_next = $signed({c0[U-1], c0}) - $signed({a0[U-1], a0});
    dv2_next = $signed({c1[U-1], c1}) - $signed({a1[U-1], a1});
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dp1[k] <= dp1_next[k];
      dp2[k] <= dp2_next[k];
    end
    du1 <= du1_next;
    dv1 <= dv1_next;
    du2 <= du2_next;
    dv2 <= dv2_next;
  end

  // stage 2: products
  logic signed [PRW-1:0] pt1 [3];
  logic signed [PRW-1:0] pt2 [3];
  logic signed [PRW-1:0] pq1 [3];
  logic signed [PRW-1:0] pq2 [3];
  logic signed [DPW-1:0] dt1, dt2;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pt1[k] <= dp1[k] * dv2;
      pt2[k] <= dp2[k] * dv1;
      pq1[k] <= dp2[k] * du1;
      pq2[k] <= dp1[k] * du2;
    end
    dt1 <= du1 * dv2;
    dt2 <= dv1 * du2;
  end

  // stage 3: differences
  logic signed [NW-1:0] num [6];
  logic signed [DW-1:0] det;
  logic                 degen;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num[k]   <= $signed({pt1[k][PRW-1], pt1[k]}) - $signed({pt2[k][PRW-1], pt2[k]});
      num[k+3] <= $signed({pq1[k][PRW-1], pq1[k]}) - $signed({pq2[k][PRW-1], pq2[k]});
    end
    det   <= $signed({dt1[DPW-1], dt1}) - $signed({dt2[DPW-1], dt2});
    degen <= (dt1 == dt2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    payload = '0;
    for (int l = 0; l < 6; l++) begin
      payload[l*NW +: NW] = num[l];
    end
    payload[6*NW +: DW] = det;
    payload[6*NW+DW]    = degen;
  end

  assign push = v3;

endmodule

// ----- rtl/core/ttb_queue.sv -----
// ----------------------------------------------------------------------------
// ttb_queue : two-entry queue
// Decouples the decode front from the divider back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  assign dout  = mem[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

endmodule

// ----- rtl/core/ttb_div_lane.sv -----
// ----------------------------------------------------------------------------
// ttb_div_lane : pipelined rounding divider
// num * 2^QSHIFT / den, half away from zero, saturated to Q16.16.
// Magnitude and scale, then restoring steps: 35 stages plus output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_div_lane #(
  parameter int NW = 35,
  parameter int DW = 35
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ttb_pkg::ctl_t                     ctl_in,
  input  logic signed [NW-1:0]              num,
  input  logic signed [DW-1:0]              den,
  output ttb_pkg::ctl_t                     ctl_out,
  output logic signed [ttb_pkg::OUT_W-1:0]  quot
);

  localparam int QB    = ttb_pkg::QBITS;
  localparam int SW    = NW + ttb_pkg::QSHIFT + 1;
  localparam int WW    = (SW > DW + QB + 1) ? SW : DW + QB + 1;
  localparam int STEPS = QB + 1;

  // magnitudes
  logic [NW-1:0]  nm;
  logic [DW-1:0]  dm;
  logic           ng0;
  ttb_pkg::ctl_t  c0;

  always_ff @(posedge clk) begin
    nm  <= num[NW-1] ? (~num + 1'b1) : num;
    dm  <= den[DW-1] ? (~den + 1'b1) : den;
    ng0 <= num[NW-1] ^ den[DW-1];
  end

  logic [WW-1:0]  rem [0:STEPS];
  logic [DW-1:0]  dvs [0:STEPS];
  logic [QB-1:0]  qv  [0:STEPS];
  logic           neg [0:STEPS];
  logic           sat [0:STEPS];
  ttb_pkg::ctl_t  ctl [0:STEPS];

  // scaled numerator plus half divisor
  always_ff @(posedge clk) begin
    rem[0] <= (WW'(nm) << ttb_pkg::QSHIFT) + WW'(dm >> 1);
    dvs[0] <= dm;
    qv[0]  <= '0;
    neg[0] <= ng0;
    sat[0] <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c0     <= '0;
      ctl[0] <= '0;
    end else begin
      c0     <= ctl_in;
      ctl[0] <= c0;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int B = QB - j;
    logic [WW-1:0] dsh;
    logic          ge;

    assign dsh = WW'(dvs[j]) << B;
    assign ge  = (rem[j] >= dsh);

    if (j == 0) begin : g_ovf
      // quotient would need more than QB bits
      always_ff @(posedge clk) begin
        rem[j+1] <= rem[j];
        qv[j+1]  <= qv[j];
        sat[j+1] <= ge;
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        rem[j+1] <= ge ? (rem[j] - dsh) : rem[j];
        qv[j+1]  <= qv[j] | (ge ? (QB'(1) << B) : '0);
        sat[j+1] <= sat[j];
      end
    end

    always_ff @(posedge clk) begin
      dvs[j+1] <= dvs[j];
      neg[j+1] <= neg[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[j+1] <= '0;
      end else begin
        ctl[j+1] <= ctl[j];
      end
    end
  end

  logic signed [ttb_pkg::OUT_W-1:0] res;
  logic [QB-1:0]                    qf;

  assign qf = qv[STEPS];

  always_comb begin
    if (ctl[STEPS].degenerate) begin
      res = '0;
    end else if (neg[STEPS]) begin
      if (sat[STEPS] || (qf > {1'b1, {(QB-1){1'b0}}})) begin
        res = {1'b1, {(QB-1){1'b0}}};
      end else begin
        res = ~qf + 1'b1;
      end
    end else begin
      if (sat[STEPS] || qf[QB-1]) begin
        res = {1'b0, {(QB-1){1'b1}}};
      end else begin
        res = qf;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl[STEPS];
    end
  end

endmodule

// ----- rtl/core/ttb_back.sv -----
// ----------------------------------------------------------------------------
// ttb_back : divider bank
// Six divider lanes share one determinant; gives the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_back #(
  parameter int NW = 35,
  parameter int DW = 35
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [6*NW+DW:0]                  payload,
  output logic                              strobe,
  output logic                              degenerate,
  output logic signed [ttb_pkg::OUT_W-1:0]  res [6]
);

  ttb_pkg::ctl_t ctl_in;
  ttb_pkg::ctl_t ctl_o [6];

  assign ctl_in.valid      = take;
  assign ctl_in.degenerate = payload[6*NW+DW];

  for (genvar l = 0; l < 6; l++) begin : g_lane
    ttb_div_lane #(
      .NW(NW),
      .DW(DW)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_in),
      .num    ($signed(payload[l*NW +: NW])),
      .den    ($signed(payload[6*NW +: DW])),
      .ctl_out(ctl_o[l]),
      .quot   (res[l])
    );
  end

  always_comb begin
    strobe = 1'b1;
    for (int l = 0; l < 6; l++) begin
      strobe = strobe & ctl_o[l].valid;
    end
    degenerate = ctl_o[0].degenerate;
  end

endmodule

// ----- tb/tangent_checker.sv -----
// ----------------------------------------------------------------------------
// tangent_checker : scoreboard for the tangent/bitangent block
// Watches requests and done strobes, predicts each triangle's result and
// compares it field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tangent_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [ttb_pkg::POS_W-1:0]         pos_a,
  input  logic [ttb_pkg::POS_W-1:0]         pos_b,
  input  logic [ttb_pkg::POS_W-1:0]         pos_c,
  input  logic [ttb_pkg::UV_W-1:0]          uv_a,
  input  logic [ttb_pkg::UV_W-1:0]          uv_b,
  input  logic [ttb_pkg::UV_W-1:0]          uv_c,
  input  logic                              done,
  input  logic signed [ttb_pkg::OUT_W-1:0]  tangent_x,
  input  logic signed [ttb_pkg::OUT_W-1:0]  tangent_y,
  input  logic signed [ttb_pkg::OUT_W-1:0]  tangent_z,
  input  logic signed [ttb_pkg::OUT_W-1:0]  bitangent_x,
  input  logic signed [ttb_pkg::OUT_W-1:0]  bitangent_y,
  input  logic signed [ttb_pkg::OUT_W-1:0]  bitangent_z,
  input  logic                              degenerate,
  output int                                fail_count,
  output int                                pending,
  output int                                degen_seen
);

  typedef struct {
    logic signed [31:0] tan [3];
    logic signed [31:0] bit_v [3];
    logic               degen;
  } frame_t;

  frame_t frame_q[$];

  function automatic longint comp(logic [63:0] w, int idx, int bits);
    logic [63:0] raw;
    raw = (w >> (idx * bits)) & ((64'd1 << bits) - 1);
    if (raw[bits-1]) return longint'(raw) - (longint'(1) << bits);
    return longint'(raw);
  endfunction

  // num * 2^QSHIFT / det, rounded half away from zero, saturated
  function automatic logic signed [31:0] fix_div(longint num, longint det);
    logic neg;
    longint unsigned nm, dm, q;
    neg = (num < 0) != (det < 0);
    nm = (num < 0) ? -num : num;
    dm = (det < 0) ? -det : det;
    q = ((nm << ttb_pkg::QSHIFT) + (dm >> 1)) / dm;
    if (neg) begin
      if (q > 64'h8000_0000) return 32'sh8000_0000;
      return -$signed(q[31:0]);
    end
    if (q > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return $signed(q[31:0]);
  endfunction

  function automatic frame_t predict_frame(
      logic [47:0] pa, logic [47:0] pb, logic [47:0] pc,
      logic [31:0] ta, logic [31:0] tb, logic [31:0] tc);
    frame_t f;
    longint dp1, dp2, du1, dv1, du2, dv2, det;
    int cb, ub;
    cb = ttb_pkg::COORD_BITS_DEF;
    ub = ttb_pkg::UV_BITS_DEF;
    du1 = comp(tb, 0, ub) - comp(ta, 0, ub);
    dv1 = comp(tb, 1, ub) - comp(ta, 1, ub);
    du2 = comp(tc, 0, ub) - comp(ta, 0, ub);
    dv2 = comp(tc, 1, ub) - comp(ta, 1, ub);
    det = du1 * dv2 - dv1 * du2;
    f.degen = (det == 0);
    for (int k = 0; k < 3; k++) begin
      dp1 = comp(pb, k, cb) - comp(pa, k, cb);
      dp2 = comp(pc, k, cb) - comp(pa, k, cb);
      if (det == 0) begin
        f.tan[k] = '0;
        f.bit_v[k] = '0;
      end else begin
        f.tan[k] = fix_div(dp1 * dv2 - dp2 * dv1, det);
        f.bit_v[k] = fix_div(dp2 * du1 - dp1 * du2, det);
      end
    end
    return f;
  endfunction

  task automatic cmp(string name, logic signed [31:0] exp_v, logic signed [31:0] act);
    if (exp_v !== act) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    degen_seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    frame_t e;
    if (!rst) begin
      if (start && !busy)
        frame_q.push_back(predict_frame(pos_a, pos_b, pos_c, uv_a, uv_b, uv_c));
      if (done) begin
        if (frame_q.size() == 0) begin
          $error("result strobe with no request outstanding");
          fail_count++;
        end else begin
          e = frame_q.pop_front();
          cmp("tangent_x", e.tan[0], tangent_x);
          cmp("tangent_y", e.tan[1], tangent_y);
          cmp("tangent_z", e.tan[2], tangent_z);
          cmp("bitangent_x", e.bit_v[0], bitangent_x);
          cmp("bitangent_y", e.bit_v[1], bitangent_y);
          cmp("bitangent_z", e.bit_v[2], bitangent_z);
          cmp("degenerate", 32'(e.degen), 32'(degenerate));
          if (e.degen) degen_seen++;
        end
      end
    end
    pending = frame_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench : top level for the tangent/bitangent block
// Drives directed and random triangles with random request gaps; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int N_RANDOM    = 1400;
  localparam int CALM_TAIL   = 200;     // last requests go back to back
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int DRAIN_WAIT  = 60;      // margin beyond the pipeline latency

  logic clk, rst, start, busy, done, degenerate;
  logic [47:0] pos_a, pos_b, pos_c;
  logic [31:0] uv_a, uv_b, uv_c;
  logic signed [31:0] tangent_x, tangent_y, tangent_z;
  logic signed [31:0] bitangent_x, bitangent_y, bitangent_z;
  int fail_count, pending, degen_seen;
  int cycles, sent;

  triangle_tangent_bitangent u_top (.*);

  tangent_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung pipeline or lost result ends here
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // three Q8.8 components packed x low
  function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] pack2(logic [15:0] u, logic [15:0] v);
    return {v, u};
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Issue one request; start stays high so back-to-back requests need no
  // lowering. Busy is sampled mid-cycle, where it is stable.
  task automatic send(logic [47:0] pa, logic [47:0] pb, logic [47:0] pc,
                      logic [31:0] ta, logic [31:0] tb, logic [31:0] tc);
    logic ok;
    pos_a <= pa; pos_b <= pb; pos_c <= pc;
    uv_a <= ta; uv_b <= tb; uv_c <= tc;
    start <= 1'b1;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    sent++;
  endtask

  // random idle gap, drawn about a third of the time
  task automatic maybe_gap();
    if ($urandom_range(2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  localparam logic [15:0] ONE_UV = 16'h1000;  // 1.0 in Q4.12

  initial begin
    logic [31:0] ta, tb, tc;
    logic [47:0] pa;
    int mode, drain;
    rst = 1'b1;
    start = 1'b0;
    pos_a = '0; pos_b = '0; pos_c = '0;
    uv_a = '0; uv_b = '0; uv_c = '0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // all zero: degenerate
    send('0, '0, '0, '0, '0, '0);
    // all ones: every UV equal, degenerate
    send('1, '1, '1, '1, '1, '1);
    // unit UV frame, unit edges: tangent = dp1, bitangent = dp2
    send('0, pack3(16'h0100, 0, 0), pack3(0, 16'h0100, 0),
         '0, pack2(ONE_UV, 0), pack2(0, ONE_UV));
    // flipped UV: negative determinant
    send('0, pack3(16'h0100, 16'h0080, 16'hFF00), pack3(0, 16'h0100, 16'h0040),
         '0, pack2(0, ONE_UV), pack2(ONE_UV, 0));
    // extreme positions, minimal determinant: saturation high and low
    send(pack3(16'h8000, 16'h8000, 16'h8000), pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
         pack3(16'h8000, 16'h7FFF, 16'h8000), '0, pack2(1, 0), pack2(0, 1));
    send(pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), pack3(16'h8000, 16'h8000, 16'h8000),
         pack3(16'h7FFF, 16'h8000, 16'h7FFF), '0, pack2(1, 0), pack2(0, 1));
    // extreme UVs: largest determinant, small result
    send(pack3(16'h7FFF, 0, 16'h8000), pack3(16'h8000, 16'h7FFF, 0), '0,
         pack2(16'h8000, 16'h8000), pack2(16'h7FFF, 16'h8000),
         pack2(16'h8000, 16'h7FFF));
    send(pack3(16'h8000, 16'h7FFF, 1), '1, pack3(16'h7FFF, 16'h8000, 16'hFFFF),
         pack2(16'h7FFF, 16'h7FFF), pack2(16'h8000, 16'h7FFF),
         pack2(16'h7FFF, 16'h8000));
    // collinear UVs: nonzero deltas but zero determinant
    send(rand48(), rand48(), rand48(), pack2(0, 0), pack2(16'h0800, 16'h0400),
         pack2(16'h1000, 16'h0800));
    // small determinants, det = 2 and det = 8, some odd numerators
    send('0, pack3(1, 3, 16'hFFFF), pack3(16'hFFFD, 5, 7),
         '0, pack2(2, 0), pack2(0, 1));
    send('0, pack3(16'hFFFF, 1, 2), pack3(3, 16'hFFFF, 1),
         '0, pack2(3, 1), pack2(1, 3));
    for (int i = 0; i < 8; i++)
      send(rand48(), rand48(), rand48(), $urandom, $urandom, $urandom);

    // --- random ---
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(9);
      pa = rand48();
      ta = $urandom;
      if (mode < 3) begin
        // fully random fields
        tb = $urandom;
        tc = $urandom;
        send(pa, rand48(), rand48(), ta, tb, tc);
      end else if (mode < 5) begin
        // tiny UV deltas: large quotients, frequent saturation
        tb = pack2(ta[15:0] + 16'($urandom_range(6)) - 16'd3,
                   ta[31:16] + 16'($urandom_range(6)) - 16'd3);
        tc = pack2(ta[15:0] + 16'($urandom_range(6)) - 16'd3,
                   ta[31:16] + 16'($urandom_range(6)) - 16'd3);
        send(pa, rand48(), rand48(), ta, tb, tc);
      end else if (mode == 5) begin
        // degenerate: a repeated UV, or a scaled delta (not degenerate if a sum wraps)
        case ($urandom_range(2))
          0: send(pa, rand48(), rand48(), ta, ta, $urandom);
          1: send(pa, rand48(), rand48(), ta, $urandom, ta);
          default: begin
            tb = pack2(ta[15:0] + 16'($urandom_range(255)),
                       ta[31:16] + 16'($urandom_range(255)));
            tc = pack2(16'(ta[15:0] + 16'd2 * (tb[15:0] - ta[15:0])),
                       16'(ta[31:16] + 16'd2 * (tb[31:16] - ta[31:16])));
            send(pa, rand48(), rand48(), ta, tb, tc);
          end
        endcase
      end else begin
        // mesh-like: small positions and UVs in [0,1)
        ta = pack2(16'($urandom_range(4095)), 16'($urandom_range(4095)));
        tb = pack2(16'($urandom_range(4095)), 16'($urandom_range(4095)));
        tc = pack2(16'($urandom_range(4095)), 16'($urandom_range(4095)));
        pa = pack3(16'($urandom_range(2047)) - 16'd1024,
                   16'($urandom_range(2047)) - 16'd1024,
                   16'($urandom_range(2047)) - 16'd1024);
        send(pa, pa + pack3(16'($urandom_range(511)), 16'($urandom_range(511)),
                            16'($urandom_range(511))),
             pa + pack3(16'($urandom_range(511)), 16'($urandom_range(511)),
                        16'($urandom_range(511))), ta, tb, tc);
      end
      if (i < N_RANDOM - CALM_TAIL) maybe_gap();
    end
    start <= 1'b0;

    // drain: wait, up to a bound, for every outstanding result, then a margin beyond the latency
    drain = 0;
    while (pending != 0 && drain < 10 * DRAIN_WAIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d triangles (%0d degenerate results) in %0d cycles.",
             sent, degen_seen, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("Failures: %0d, results still outstanding: %0d", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ttb_pkg.sv
rtl/core/ttb_front.sv
rtl/core/ttb_queue.sv
rtl/core/ttb_div_lane.sv
rtl/core/ttb_back.sv
rtl/core/triangle_tangent_bitangent.sv
tb/tangent_checker.sv
tb/testbench.sv
